// ===== rtl/rm2q_pkg.sv =====
// ----------------------------------------------------------------------------
// rm2q_pkg
// Types and constants shared by the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rm2q_pkg;

    localparam int ElemW  = 16;
    localparam int QuatW  = 20;
    localparam int ArgW   = 19;   // radicand, 0 .. 4096 + 3*32768
    localparam int RadW   = ArgW + 21;  // A * 2^20 padded to an even width
    localparam int RootW  = 20;   // sqrt of RadW bits
    localparam int DiffW  = 17;   // sum/difference of two entries
    localparam int NumW   = DiffW + 19;
    localparam int QuoW   = NumW - 16;  // root >= 2^16 when nonzero

    localparam int SqrtSteps = RootW;   // one result bit per stage
    localparam int DivSteps  = QuoW;    // one quotient bit per stage

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_ROW0  = 2'd1,
        CASE_ROW1  = 2'd2,
        CASE_ROW2  = 2'd3
    } t_case;

    typedef struct packed {
        logic signed [ElemW-1:0] r0c0, r0c1, r0c2;
        logic signed [ElemW-1:0] r1c0, r1c1, r1c2;
        logic signed [ElemW-1:0] r2c0, r2c1, r2c2;
    } t_matrix;

    typedef struct packed {
        logic signed [QuatW-1:0] w, x, y, z;
        logic [1:0]              case_taken;
    } t_quat;

    // three numerators to be divided plus the case select, carried through the pipe
    typedef struct packed {
        t_case                   sel;
        logic signed [DiffW-1:0] d0, d1, d2;
    } t_front;

    function automatic logic signed [QuatW-1:0] sat_quo(
        input logic neg, input logic [QuoW-1:0] q);
        logic signed [QuoW:0] v;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > $signed((QuoW+1)'(524287)))
            return QuatW'(524287);
        else if (v < -$signed((QuoW+1)'(524288)))
            return -(QuatW'(524288));
        return v[QuatW-1:0];
    endfunction

endpackage

// ===== rtl/rm2q_stream_if.sv =====
// ----------------------------------------------------------------------------
// rm2q_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface rm2q_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rm2q_front.sv =====
// ----------------------------------------------------------------------------
// rm2q_front
// Case select, radicand and off-diagonal sums. Two register stages.
// ----------------------------------------------------------------------------
module rm2q_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  rm2q_pkg::t_matrix                 i_m,
    output logic                              o_valid,
    output logic [rm2q_pkg::ArgW-1:0]         o_arg,
    output rm2q_pkg::t_front                  o_front
);
    localparam int AW = rm2q_pkg::ArgW;
    localparam int DW = rm2q_pkg::DiffW;

    logic                    r_v1, r_v2;
    logic signed [AW+1:0]    r_tr;
    rm2q_pkg::t_matrix       r_m;
    logic                    r_g0, r_g1;
    logic [AW-1:0]           r_arg;
    rm2q_pkg::t_front        r_front;

    logic signed [AW+1:0]    n_tr;
    logic signed [AW+1:0]    w_a;
    rm2q_pkg::t_case         w_sel;
    logic signed [DW-1:0]    w_wx, w_wy, w_wz, w_pxy, w_pxz, w_pyz;

    assign n_tr = (AW+2)'(i_m.r0c0) + (AW+2)'(i_m.r1c1) + (AW+2)'(i_m.r2c2);

    always_comb begin
        w_wx  = DW'(r_m.r1c2) - DW'(r_m.r2c1);
        w_wy  = DW'(r_m.r2c0) - DW'(r_m.r0c2);
        w_wz  = DW'(r_m.r0c1) - DW'(r_m.r1c0);
        w_pxy = DW'(r_m.r1c0) + DW'(r_m.r0c1);
        w_pxz = DW'(r_m.r2c0) + DW'(r_m.r0c2);
        w_pyz = DW'(r_m.r2c1) + DW'(r_m.r1c2);
        if (r_tr > 0)     w_sel = rm2q_pkg::CASE_TRACE;
        else if (r_g0)    w_sel = rm2q_pkg::CASE_ROW0;
        else if (r_g1)    w_sel = rm2q_pkg::CASE_ROW1;
        else              w_sel = rm2q_pkg::CASE_ROW2;
        case (w_sel)
            rm2q_pkg::CASE_TRACE: w_a = r_tr;
            rm2q_pkg::CASE_ROW0:  w_a = ((AW+2)'(r_m.r0c0) <<< 1) - r_tr;
            rm2q_pkg::CASE_ROW1:  w_a = ((AW+2)'(r_m.r1c1) <<< 1) - r_tr;
            default:              w_a = ((AW+2)'(r_m.r2c2) <<< 1) - r_tr;
        endcase
        w_a = w_a + (AW+2)'(4096);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_m   <= i_m;
            r_tr  <= n_tr;
            r_g0  <= (i_m.r0c0 > i_m.r1c1) && (i_m.r0c0 > i_m.r2c2);
            r_g1  <= i_m.r1c1 > i_m.r2c2;
            r_arg <= (w_a < 0) ? '0 : w_a[AW-1:0];
            r_front.sel <= w_sel;
            case (w_sel)
                rm2q_pkg::CASE_TRACE: begin
                    r_front.d0 <= w_wx;  r_front.d1 <= w_wy;  r_front.d2 <= w_wz;
                end
                rm2q_pkg::CASE_ROW0: begin
                    r_front.d0 <= w_wx;  r_front.d1 <= w_pxy; r_front.d2 <= w_pxz;
                end
                rm2q_pkg::CASE_ROW1: begin
                    r_front.d0 <= w_wy;  r_front.d1 <= w_pxy; r_front.d2 <= w_pyz;
                end
                default: begin
                    r_front.d0 <= w_wz;  r_front.d1 <= w_pxz; r_front.d2 <= w_pyz;
                end
            endcase
        end
    end

    assign o_valid = r_v2;
    assign o_arg   = r_arg;
    assign o_front = r_front;
endmodule

// ===== rtl/rm2q_sqrt.sv =====
// ----------------------------------------------------------------------------
// rm2q_sqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rm2q_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [rm2q_pkg::ArgW-1:0]         i_arg,
    input  rm2q_pkg::t_front                  i_front,
    output logic                              o_valid,
    output logic [rm2q_pkg::RootW-1:0]        o_root,
    output rm2q_pkg::t_front                  o_front
);
    localparam int N  = rm2q_pkg::SqrtSteps;
    localparam int RW = rm2q_pkg::RadW;
    localparam int QW = rm2q_pkg::RootW;
    localparam int PW = QW + 2;

    logic                    r_v   [N];
    logic [RW-1:0]           r_rad [N];
    logic [PW-1:0]           r_rem [N];
    logic [QW-1:0]           r_q   [N];
    rm2q_pkg::t_front        r_f   [N];

    logic [RW-1:0]           w_rad [N];
    logic [PW-1:0]           w_rem [N];
    logic [QW-1:0]           w_q   [N];

    // stage k consumes the next two radicand bits (MSB first)
    always_comb begin
        for (int k = 0; k < N; k++) begin
            logic [RW-1:0] rad_in;
            logic [PW-1:0] rem_in, trial, rem_sh;
            logic [QW-1:0] q_in;
            rad_in = (k == 0) ? {1'b0, i_arg, 20'd0} : r_rad[k-1];
            rem_in = (k == 0) ? '0 : r_rem[k-1];
            q_in   = (k == 0) ? '0 : r_q[k-1];
            rem_sh = {rem_in[PW-3:0], rad_in[RW-1 -: 2]};
            trial  = PW'({q_in, 2'b01});
            w_rad[k] = {rad_in[RW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                w_rem[k] = rem_sh - trial;
                w_q[k]   = {q_in[QW-2:0], 1'b1};
            end else begin
                w_rem[k] = rem_sh;
                w_q[k]   = {q_in[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (!i_rst_n)
                r_v[k] <= 1'b0;
            else if (i_en)
                r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            if (i_en) begin
                r_rad[k] <= w_rad[k];
                r_rem[k] <= w_rem[k];
                r_q[k]   <= w_q[k];
                r_f[k]   <= (k == 0) ? i_front : r_f[k-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_q[N-1];
    assign o_front = r_f[N-1];
endmodule

// ===== rtl/rm2q_div.sv =====
// ----------------------------------------------------------------------------
// rm2q_div
// Three pipelined restoring dividers sharing one divisor, plus output pack.
// ----------------------------------------------------------------------------
module rm2q_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [rm2q_pkg::RootW-1:0]        i_root,
    input  rm2q_pkg::t_front                  i_front,
    output logic                              o_valid,
    output rm2q_pkg::t_quat                   o_quat
);
    localparam int N  = rm2q_pkg::DivSteps;
    localparam int NW = rm2q_pkg::NumW;
    localparam int QW = rm2q_pkg::QuoW;
    localparam int RW = rm2q_pkg::RootW;
    localparam int DW = rm2q_pkg::DiffW;

    logic                    r_v    [N+1];
    logic [RW-1:0]           r_dv   [N];
    rm2q_pkg::t_case         r_sel  [N];
    logic [2:0]              r_neg  [N];
    logic [NW-1:0]           r_num  [N][3];
    logic [RW:0]             r_rem  [N][3];
    logic [QW-1:0]           r_q    [N][3];
    rm2q_pkg::t_quat         r_out;

    logic [NW-1:0]           w_num  [N][3];
    logic [RW:0]             w_rem  [N][3];
    logic [QW-1:0]           w_q    [N][3];
    logic [2:0]              w_neg0;
    logic [NW-1:0]           w_mag0 [3];
    logic signed [rm2q_pkg::QuatW-1:0] w_c [3];
    logic [rm2q_pkg::QuatW-1:0] w_quarter;

    always_comb begin
        logic signed [DW-1:0] d [3];
        d[0] = i_front.d0;  d[1] = i_front.d1;  d[2] = i_front.d2;
        for (int j = 0; j < 3; j++) begin
            logic [DW-1:0] mag;
            w_neg0[j] = d[j][DW-1];
            mag = w_neg0[j] ? DW'(-d[j]) : DW'(d[j]);
            w_mag0[j] = {mag, 19'd0};
        end
    end

    // only the low QW numerator bits can produce quotient bits: the top 16
    // never reach a divisor of at least 2^16
    always_comb begin
        for (int k = 0; k < N; k++) begin
            for (int j = 0; j < 3; j++) begin
                logic [NW-1:0] num_in;
                logic [RW:0]   rem_in, rem_sh;
                logic [QW-1:0] q_in;
                logic [RW-1:0] dv;
                num_in = (k == 0) ? w_mag0[j] : r_num[k-1][j];
                dv     = (k == 0) ? i_root : r_dv[k-1];
                rem_in = (k == 0) ? (RW+1)'(w_mag0[j][NW-1 -: (NW-QW)]) : r_rem[k-1][j];
                q_in   = (k == 0) ? '0 : r_q[k-1][j];
                rem_sh = {rem_in[RW-1:0], num_in[QW-1]};
                w_num[k][j] = {num_in[NW-2:0], 1'b0};
                if (k == 0) begin
                    rem_sh = (RW+1)'({w_mag0[j][NW-1 -: (NW-QW)], num_in[QW-1]});
                end
                if (rem_sh >= {1'b0, dv}) begin
                    w_rem[k][j] = rem_sh - {1'b0, dv};
                    w_q[k][j]   = {q_in[QW-2:0], 1'b1};
                end else begin
                    w_rem[k][j] = rem_sh;
                    w_q[k][j]   = {q_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic [RW-1:0] rt;
        rt = r_dv[N-1];
        w_quarter = rm2q_pkg::QuatW'(rt >> 1);
        for (int j = 0; j < 3; j++)
            w_c[j] = (rt == '0) ? '0 : rm2q_pkg::sat_quo(r_neg[N-1][j], r_q[N-1][j]);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= N; k++) begin
            if (!i_rst_n)
                r_v[k] <= 1'b0;
            else if (i_en)
                r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
        end
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_dv[k]  <= (k == 0) ? i_root : r_dv[k-1];
                r_sel[k] <= (k == 0) ? i_front.sel : r_sel[k-1];
                r_neg[k] <= (k == 0) ? w_neg0 : r_neg[k-1];
                for (int j = 0; j < 3; j++) begin
                    r_num[k][j] <= w_num[k][j];
                    r_rem[k][j] <= w_rem[k][j];
                    r_q[k][j]   <= w_q[k][j];
                end
            end
            r_out.case_taken <= r_sel[N-1];
            case (r_sel[N-1])
                rm2q_pkg::CASE_TRACE: begin
                    r_out.w <= w_quarter; r_out.x <= w_c[0];
                    r_out.y <= w_c[1];    r_out.z <= w_c[2];
                end
                rm2q_pkg::CASE_ROW0: begin
                    r_out.w <= w_c[0];    r_out.x <= w_quarter;
                    r_out.y <= w_c[1];    r_out.z <= w_c[2];
                end
                rm2q_pkg::CASE_ROW1: begin
                    r_out.w <= w_c[0];    r_out.x <= w_c[1];
                    r_out.y <= w_quarter; r_out.z <= w_c[2];
                end
                default: begin
                    r_out.w <= w_c[0];    r_out.x <= w_c[1];
                    r_out.y <= w_c[2];    r_out.z <= w_quarter;
                end
            endcase
        end
    end

    assign o_valid = r_v[N];
    assign o_quat  = r_out;
endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Throughput: one matrix per cycle; the whole pipe advances together and
// freezes only while a result sits at the output and is not taken.
// The square root (one bit per stage) and the dividers (one quotient bit
// per stage) set the depth.
// Reset: synchronous, active low; clears all stage valid bits.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Fixed-point 3x3 rotation matrix to quaternion converter, fully pipelined.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic i_clk,
    input  logic i_rst_n,
    rm2q_stream_if.sink   i_mat,
    rm2q_stream_if.source o_quat
);
    logic                             w_en;
    logic                             w_fv, w_sv;
    logic [rm2q_pkg::ArgW-1:0]        w_arg;
    logic [rm2q_pkg::RootW-1:0]       w_root;
    rm2q_pkg::t_front                 w_ff, w_sf;

    // pipe moves whenever the output slot is empty or being drained
    assign w_en        = !o_quat.valid || o_quat.ready;
    assign i_mat.ready = w_en;

    rm2q_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_mat.valid), .i_m(i_mat.data),
        .o_valid(w_fv), .o_arg(w_arg), .o_front(w_ff)
    );

    rm2q_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_fv), .i_arg(w_arg), .i_front(w_ff),
        .o_valid(w_sv), .o_root(w_root), .o_front(w_sf)
    );

    rm2q_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_sv), .i_root(w_root), .i_front(w_sf),
        .o_valid(o_quat.valid), .o_quat(o_quat.data)
    );
endmodule

// ===== rtl/rm2q_checker.sv =====
// ----------------------------------------------------------------------------
// rm2q_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rm2q_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input rm2q_pkg::t_quat i_out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output beat changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while output stalled");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind rotation_matrix_to_quaternion rm2q_checker u_chk (
    .i_clk, .i_rst_n,
    .i_in_ready(i_mat.ready),
    .i_out_valid(o_quat.valid), .i_out_ready(o_quat.ready), .i_out_data(o_quat.data)
);
